// ----- hw/rtl/ffa_pkg.sv -----
`default_nettype none

package ffa_pkg;

    localparam int ARENA_BYTES      = 256;
    localparam int SIZE_FIELD_BYTES = 4;
    localparam int MIN_BLOCK_BYTES  = 8;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] req_size;
        logic [7:0] free_addr;
    } req_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] data_addr;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ffa_ram.sv -----
`default_nettype none

module ffa_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/first_fit_free_list_allocator.sv -----
`default_nettype none

// First-fit allocator over an arena whose block sizes and links live in two
// single-port-read RAMs (registered read). start is taken while busy
// is low; exactly one result follows, shown on result for one cycle with
// done high, and it cannot be held off. An allocate walks the free blocks,
// merges each adjacent free neighbor into the visited block, then writes back;
// a free walks the list up to the insertion point, then links the block in.
// Every walk is limited to 2*ARENA_BYTES steps; no new start is taken before
// done. No clearing pass after reset: only the first block is defined.
module first_fit_free_list_allocator #(
    parameter int ARENA_BYTES      = ffa_pkg::ARENA_BYTES,
    parameter int SIZE_FIELD_BYTES = ffa_pkg::SIZE_FIELD_BYTES,
    parameter int MIN_BLOCK_BYTES  = ffa_pkg::MIN_BLOCK_BYTES
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire ffa_pkg::req_t   req,
    output logic                 busy,
    output logic                 done,
    output ffa_pkg::result_t     result
);

    localparam int AW    = $clog2(ARENA_BYTES);
    localparam int PW    = AW + 1;
    localparam int CW    = ((PW > 9) ? PW : 9) + 1;
    localparam int STW   = AW + 2;
    localparam int LIMIT = 2 * ARENA_BYTES;

    typedef enum logic [3:0] {
        S_IDLE, S_A_CHK, S_A_RD, S_A_MCHK, S_A_MRD, S_A_MWR, S_A_FIT,
        S_A_WR1, S_A_WR2, S_F_START, S_F_CHK, S_F_RD, S_F_WR1, S_F_WR2
    } state_t;

    state_t            state_reg;
    logic [PW-1:0]     head_reg;
    logic [PW-1:0]     cur_reg;
    logic [PW-1:0]     prev_reg;
    logic [PW-1:0]     nxt_reg;
    logic [PW-1:0]     sz_reg;
    logic [PW-1:0]     ln_reg;
    logic [CW-1:0]     need_reg;
    logic [STW-1:0]    steps_reg;
    logic              done_reg;
    ffa_pkg::result_t  result_reg;
    logic              size0_rst_reg;
    logic              link0_rst_reg;
    logic              rd_size0_reg;
    logic              rd_link0_reg;

    logic              size_we;
    logic [AW-1:0]     size_wa;
    logic [PW-1:0]     size_wd;
    logic              link_we;
    logic [AW-1:0]     link_wa;
    logic [PW-1:0]     link_wd;
    logic [AW-1:0]     rd_addr;
    logic [PW-1:0]     size_q;
    logic [PW-1:0]     link_q;
    logic [PW-1:0]     size_rd;
    logic [PW-1:0]     link_rd;

    logic [CW-1:0]     tgt;
    logic [CW-1:0]     sz_w;
    logic [CW-1:0]     left;
    logic [CW-1:0]     split_at;
    logic              steps_ok;
    logic [CW-1:0]     faddr_w;
    logic [CW-1:0]     blk_w;
    logic [CW-1:0]     req_w;

    localparam logic [PW-1:0] NIL = PW'(ARENA_BYTES);

    ffa_ram #(.WIDTH(PW), .DEPTH(ARENA_BYTES)) u_size_ram (
        .clk   (clk),
        .we    (size_we),
        .waddr (size_wa),
        .wdata (size_wd),
        .raddr (rd_addr),
        .rdata (size_q)
    );

    ffa_ram #(.WIDTH(PW), .DEPTH(ARENA_BYTES)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_wa),
        .wdata (link_wd),
        .raddr (rd_addr),
        .rdata (link_q)
    );

    // entry zero holds the whole arena until first written
    assign size_rd = rd_size0_reg ? NIL : size_q;
    assign link_rd = rd_link0_reg ? NIL : link_q;

    assign sz_w     = CW'(sz_reg);
    assign tgt      = CW'(cur_reg) + sz_w;
    assign left     = sz_w - need_reg;
    assign split_at = CW'(cur_reg) + need_reg;
    assign steps_ok = steps_reg < STW'(LIMIT);
    assign faddr_w  = CW'(req.free_addr);
    assign blk_w    = faddr_w - CW'(SIZE_FIELD_BYTES);
    assign req_w    = CW'(req.req_size);

    always_comb
    begin
        size_we = 1'b0;
        size_wa = cur_reg[AW-1:0];
        size_wd = sz_reg;
        link_we = 1'b0;
        link_wa = cur_reg[AW-1:0];
        link_wd = ln_reg;
        rd_addr = cur_reg[AW-1:0];
        case (state_reg)
            S_A_MCHK:
            begin
                rd_addr = tgt[AW-1:0];
            end
            S_A_MWR:
            begin
                size_we = 1'b1;
                link_we = 1'b1;
            end
            S_A_WR1:
            begin
                size_we = 1'b1;
                size_wa = nxt_reg[AW-1:0];
                size_wd = left[PW-1:0];
                link_we = 1'b1;
                link_wa = nxt_reg[AW-1:0];
                link_wd = ln_reg;
            end
            S_A_WR2:
            begin
                size_we = 1'b1;
                size_wd = need_reg[PW-1:0];
                link_we = (prev_reg < NIL);
                link_wa = prev_reg[AW-1:0];
                link_wd = nxt_reg;
            end
            S_F_START:
            begin
                link_we = (head_reg >= NIL) || (cur_reg < head_reg);
                link_wd = (head_reg >= NIL) ? NIL : head_reg;
            end
            S_F_CHK:
            begin
                rd_addr = prev_reg[AW-1:0];
            end
            S_F_WR1:
            begin
                link_we = 1'b1;
                link_wd = ln_reg;
            end
            S_F_WR2:
            begin
                link_we = 1'b1;
                link_wa = prev_reg[AW-1:0];
                link_wd = cur_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            done_reg      <= 1'b0;
            result_reg    <= '0;
            size0_rst_reg <= 1'b1;
            link0_rst_reg <= 1'b1;
            rd_size0_reg  <= 1'b0;
            rd_link0_reg  <= 1'b0;
            cur_reg       <= '0;
            prev_reg      <= '0;
            nxt_reg       <= '0;
            sz_reg        <= '0;
            ln_reg        <= '0;
            need_reg      <= '0;
            steps_reg     <= '0;
        end
        else
        begin
            done_reg     <= 1'b0;
            rd_size0_reg <= (rd_addr == '0) && size0_rst_reg;
            rd_link0_reg <= (rd_addr == '0) && link0_rst_reg;
            if (size_we && (size_wa == '0))
            begin
                size0_rst_reg <= 1'b0;
            end
            if (link_we && (link_wa == '0))
            begin
                link0_rst_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        steps_reg <= '0;
                        prev_reg  <= NIL;
                        if (req.func == ffa_pkg::FUNC_ALLOC)
                        begin
                            cur_reg   <= head_reg;
                            need_reg  <= (req_w < CW'(MIN_BLOCK_BYTES)) ?
                                         CW'(MIN_BLOCK_BYTES) :
                                         req_w + CW'(SIZE_FIELD_BYTES);
                            state_reg <= S_A_CHK;
                        end
                        else if ((faddr_w < CW'(SIZE_FIELD_BYTES)) ||
                                 (blk_w >= CW'(ARENA_BYTES)))
                        begin
                            done_reg   <= 1'b1;
                            result_reg <= '0;
                        end
                        else
                        begin
                            cur_reg   <= blk_w[PW-1:0];
                            state_reg <= S_F_START;
                        end
                    end
                end
                S_A_CHK:
                begin
                    if ((cur_reg >= NIL) || !steps_ok)
                    begin
                        done_reg   <= 1'b1;
                        result_reg <= '0;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_A_RD;
                    end
                end
                S_A_RD:
                begin
                    sz_reg    <= size_rd;
                    ln_reg    <= link_rd;
                    state_reg <= S_A_MCHK;
                end
                S_A_MCHK:
                begin
                    if (steps_ok && (tgt < CW'(ARENA_BYTES)) && (CW'(ln_reg) == tgt))
                    begin
                        state_reg <= S_A_MRD;
                    end
                    else
                    begin
                        steps_reg <= steps_reg + 1'b1;
                        state_reg <= S_A_FIT;
                    end
                end
                S_A_MRD:
                begin
                    sz_reg    <= sz_reg + size_rd;
                    ln_reg    <= link_rd;
                    steps_reg <= steps_reg + 1'b1;
                    state_reg <= S_A_MWR;
                end
                S_A_MWR:
                begin
                    state_reg <= S_A_MCHK;
                end
                S_A_FIT:
                begin
                    if (sz_w >= need_reg)
                    begin
                        if (left < CW'(MIN_BLOCK_BYTES))
                        begin
                            nxt_reg  <= ln_reg;
                            need_reg <= sz_w;
                            if (ln_reg < NIL)
                            begin
                                state_reg <= S_A_WR2;
                            end
                            else
                            begin
                                done_reg   <= 1'b1;
                                result_reg <= '0;
                                state_reg  <= S_IDLE;
                            end
                        end
                        else if (split_at < CW'(ARENA_BYTES))
                        begin
                            nxt_reg   <= split_at[PW-1:0];
                            state_reg <= S_A_WR1;
                        end
                        else
                        begin
                            done_reg   <= 1'b1;
                            result_reg <= '0;
                            state_reg  <= S_IDLE;
                        end
                    end
                    else
                    begin
                        prev_reg  <= cur_reg;
                        cur_reg   <= ln_reg;
                        state_reg <= S_A_CHK;
                    end
                end
                S_A_WR1:
                begin
                    state_reg <= S_A_WR2;
                end
                S_A_WR2:
                begin
                    if (prev_reg >= NIL)
                    begin
                        head_reg <= nxt_reg;
                    end
                    done_reg             <= 1'b1;
                    result_reg.ok        <= 1'b1;
                    result_reg.data_addr <= 8'(CW'(cur_reg) + CW'(SIZE_FIELD_BYTES));
                    state_reg            <= S_IDLE;
                end
                S_F_START:
                begin
                    if ((head_reg >= NIL) || (cur_reg < head_reg))
                    begin
                        head_reg   <= cur_reg;
                        done_reg   <= 1'b1;
                        result_reg <= '{ok: 1'b1, data_addr: 8'd0};
                        state_reg  <= S_IDLE;
                    end
                    else if (cur_reg == head_reg)
                    begin
                        done_reg   <= 1'b1;
                        result_reg <= '0;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        prev_reg  <= head_reg;
                        state_reg <= S_F_CHK;
                    end
                end
                S_F_CHK:
                begin
                    if (!steps_ok)
                    begin
                        done_reg   <= 1'b1;
                        result_reg <= '0;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_F_RD;
                    end
                end
                S_F_RD:
                begin
                    if ((link_rd >= NIL) || (link_rd > cur_reg))
                    begin
                        ln_reg    <= link_rd;
                        state_reg <= S_F_WR1;
                    end
                    else if (link_rd == cur_reg)
                    begin
                        done_reg   <= 1'b1;
                        result_reg <= '0;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        prev_reg  <= link_rd;
                        steps_reg <= steps_reg + 1'b1;
                        state_reg <= S_F_CHK;
                    end
                end
                S_F_WR1:
                begin
                    state_reg <= S_F_WR2;
                end
                S_F_WR2:
                begin
                    done_reg   <= 1'b1;
                    result_reg <= '{ok: 1'b1, data_addr: 8'd0};
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire
